/* rtl/min_max_vector_normalizer_core_defines.svh */
// ----------------------------------------------------------------------------
// Min-max vector normalizer assertion macros
// Concurrent check helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_VECTOR_NORMALIZER_CORE_DEFINES_SVH
`define MIN_MAX_VECTOR_NORMALIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside of reset.
`define MMVN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mmvn assertion failed");

// Condition must never be true outside of reset.
`define MMVN_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mmvn forbidden condition seen");

`else

`define MMVN_ASSERT(lbl, clk, rst_n, prop)
`define MMVN_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/mmvn_pkg.sv */
// ----------------------------------------------------------------------------
// Min-max vector normalizer package
// Sizes, command and status types shared by controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mmvn_pkg;

  // Buffer depth and sample width.
  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 16;

  // Fraction bits of the Q1.16 result; the quotient carries one more bit.
  localparam int FRAC_BITS = 16;
  localparam int QUOT_W    = FRAC_BITS + 1;

  // Derived widths.
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sample;
    logic rd_req;
    logic div_start;
    logic div_step;
    logic out_load;
  } mmvn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic out_free;
    logic last_idx;
  } mmvn_sts_t;

endpackage

`default_nettype wire

/* rtl/mmvn_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/mmvn_ctrl.sv */
// ----------------------------------------------------------------------------
// Min-max vector normalizer controller
// Sequences sample loading, buffer reads, division steps and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module mmvn_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_final_sample,
  output logic                    in_stall,
  output mmvn_pkg::mmvn_cmd_t     cmd,
  input  wire mmvn_pkg::mmvn_sts_t sts
);

  import mmvn_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Samples are only taken while loading a vector.
  assign in_stall = (state_r != S_LOAD);

  // Command decode.
  always_comb begin
    cmd             = '0;
    cmd.load_sample = (state_r == S_LOAD) && in_valid;
    cmd.rd_req      = (state_r == S_READ);
    cmd.div_start   = (state_r == S_START);
    cmd.div_step    = (state_r == S_DIV);
    cmd.out_load    = (state_r == S_PUT) && sts.out_free;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && in_final_sample) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_START;
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          state_nxt = sts.last_idx ? S_LOAD : S_READ;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/mmvn_dp.sv */
// ----------------------------------------------------------------------------
// Min-max vector normalizer datapath
// Sample buffer, running min and max, bit-serial divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmvn_dp (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic signed [mmvn_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  wire mmvn_pkg::mmvn_cmd_t                     cmd,
  output mmvn_pkg::mmvn_sts_t                          sts,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic             [mmvn_pkg::QUOT_W-1:0]      out_scaled_value,
  output logic                                         out_flat_range,
  output logic                                         out_dropped_samples,
  output logic                                         out_run_end
);

  import mmvn_pkg::*;

  // Vector bookkeeping.
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          ovf_r, ovf_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [ADDR_W-1:0]             idx_r, idx_nxt;

  // Divider state.
  logic [SAMPLE_BITS-1:0]        range_r, range_nxt;
  logic [SAMPLE_BITS-1:0]        rem_r, rem_nxt;
  logic [QUOT_W-1:0]             quot_r, quot_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [QUOT_W-1:0]             out_scaled_r;
  logic                          out_flat_r;
  logic                          out_drop_r;
  logic                          out_end_r;

  logic                          full;
  logic                          store_en;
  logic                          last_idx;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic [SAMPLE_BITS:0]          diff_ext;
  logic [SAMPLE_BITS:0]          range_ext;
  logic [SAMPLE_BITS-1:0]        diff;
  logic [SAMPLE_BITS-1:0]        range_w;
  logic                          q_top;
  logic [SAMPLE_BITS:0]          shifted;
  logic [SAMPLE_BITS:0]          sub;
  logic                          ge;
  logic                          flat;

  assign full     = (count_r == CNT_W'(MAX_SAMPLES));
  assign store_en = cmd.load_sample && !full;
  assign last_idx = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));
  assign flat     = (range_r == '0);

  // Sample buffer.
  mmvn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (in_sample_value),
    .rd_en   (cmd.rd_req),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Offset and range are non-negative, so the low bits hold them exactly.
  assign diff_ext  = {rd_data[SAMPLE_BITS-1], rd_data} - {min_r[SAMPLE_BITS-1], min_r};
  assign range_ext = {max_r[SAMPLE_BITS-1], max_r} - {min_r[SAMPLE_BITS-1], min_r};
  assign diff      = diff_ext[SAMPLE_BITS-1:0];
  assign range_w   = range_ext[SAMPLE_BITS-1:0];
  assign q_top     = (diff >= range_w);

  // One restoring division step.
  assign shifted = {rem_r, 1'b0};
  assign sub     = shifted - {1'b0, range_r};
  assign ge      = (shifted >= {1'b0, range_r});

  // Next values for bookkeeping and divider.
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    idx_nxt   = idx_r;
    range_nxt = range_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    step_nxt  = step_r;

    // Load a sample, or note that the buffer overflowed.
    if (cmd.load_sample) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == '0) begin
          min_nxt = in_sample_value;
          max_nxt = in_sample_value;
        end else begin
          if (in_sample_value < min_r) begin
            min_nxt = in_sample_value;
          end
          if (in_sample_value > max_r) begin
            max_nxt = in_sample_value;
          end
        end
      end
    end

    // The integer bit comes from a single compare since offset <= range.
    if (cmd.div_start) begin
      range_nxt = range_w;
      rem_nxt   = q_top ? (diff - range_w) : diff;
      quot_nxt  = QUOT_W'(q_top);
      step_nxt  = STEP_W'(FRAC_BITS);
    end

    // Fraction bits, one per cycle.
    if (cmd.div_step) begin
      rem_nxt  = ge ? sub[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
      quot_nxt = {quot_r[QUOT_W-2:0], ge};
      step_nxt = step_r - STEP_W'(1);
    end

    // Advance to the next stored sample or close the vector.
    if (cmd.out_load) begin
      if (last_idx) begin
        idx_nxt   = '0;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        idx_nxt = idx_r + ADDR_W'(1);
      end
    end
  end

  // Output valid: a new load wins over the transaction that empties it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Divider and output payload registers.
  always_ff @(posedge clk) begin
    range_r <= range_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    if (cmd.out_load) begin
      out_scaled_r <= flat ? '0 : quot_r;
      out_flat_r   <= flat;
      out_drop_r   <= ovf_r;
      out_end_r    <= last_idx;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts          = '0;
    sts.div_last = (step_r == STEP_W'(1));
    sts.out_free = !out_valid_r || !out_stall;
    sts.last_idx = last_idx;
  end

  assign out_valid           = out_valid_r;
  assign out_scaled_value    = out_scaled_r;
  assign out_flat_range      = out_flat_r;
  assign out_dropped_samples = out_drop_r;
  assign out_run_end         = out_end_r;

endmodule

`default_nettype wire

/* rtl/min_max_vector_normalizer_core.sv */
// ----------------------------------------------------------------------------
// Min-max vector normalizer core
// Buffers a vector of signed samples and emits each one rescaled to
// (x - min) / (max - min) in unsigned Q1.16.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   -------  -------------------  --------------------------------------------
//   in_      in_valid / in_stall  sample_value[15:0] signed, final_sample
//   out_     out_valid/out_stall  scaled_value[16:0], flat_range,
//                                 dropped_samples, run_end
//
// A sample is taken whenever in_valid is high while a vector is being loaded.
// After the final sample, each stored sample is produced in turn by a buffer
// read, a setup step, the one-bit-per-cycle restoring divider and a load of
// the output register.
// The input is stalled from the final sample until the last result is loaded.
// Reset is synchronous and clears the vector count, min, max and output valid.
// A stalled output holds its register and the divider waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_max_vector_normalizer_core_defines.svh"

module min_max_vector_normalizer_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [mmvn_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  wire logic                                    in_final_sample,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic             [mmvn_pkg::QUOT_W-1:0]      out_scaled_value,
  output logic                                         out_flat_range,
  output logic                                         out_dropped_samples,
  output logic                                         out_run_end
);

  import mmvn_pkg::*;

  mmvn_cmd_t cmd;
  mmvn_sts_t sts;

  // Sequencer.
  mmvn_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_final_sample (in_final_sample),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .sts             (sts)
  );

  // Storage, arithmetic and output register.
  mmvn_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_sample_value     (in_sample_value),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_scaled_value    (out_scaled_value),
    .out_flat_range      (out_flat_range),
    .out_dropped_samples (out_dropped_samples),
    .out_run_end         (out_run_end)
  );

  // Loading and emitting never overlap.
  `MMVN_ASSERT_NEVER(a_load_vs_emit, clk, rst_n, (in_valid && !in_stall && cmd.out_load))

  // A flat vector always reports a zero result.
  `MMVN_ASSERT(a_flat_zero, clk, rst_n, (out_valid && out_flat_range) |-> (out_scaled_value == '0))

  // A new division never ends in the cycle right after it starts.
  `MMVN_ASSERT(a_div_length, clk, rst_n, cmd.div_start |=> !sts.div_last)

endmodule

`default_nettype wire
